[rtl/binary_to_decimal_ascii_macros.svh]
// Assertion macros for the binary to decimal ASCII converter
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define B2DA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/b2da_pkg.sv]
// Shared types and constants for the binary to decimal ASCII converter
package b2da_pkg;

    localparam int NUM_W       = 32;
    localparam int CHAR_W      = 8;
    localparam int BCD_DIGITS  = 10;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int STEP_BITS   = 3;
    localparam int DD_STEPS    = 11;
    localparam int PAD_W       = STEP_BITS * DD_STEPS;
    localparam int STEP_CNT_W  = 4;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic             trim;
    } q_entry_t;

endpackage

[rtl/b2da_front.sv]
// Front end: accepts a request and converts the binary value to packed BCD
module b2da_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [b2da_pkg::NUM_W-1:0]    s_tdata,   // number
    input  logic                          s_tuser,   // trim
    output logic                          q_valid,
    input  logic                          q_ready,
    output b2da_pkg::q_entry_t            q_data
);
    import b2da_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [PAD_W-1:0]      bits_reg, bits_next;
    logic                  trim_reg, trim_next;
    logic [PAD_W-1:0]      padded;
    logic                  accept;

    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic [STEP_BITS-1:0] bits);
        logic [BCD_W-1:0] acc;
        logic [3:0]       d;
        acc = bcd;
        for (int s = STEP_BITS - 1; s >= 0; s--) begin
            for (int i = 0; i < BCD_DIGITS; i++) begin
                d = acc[i*4 +: 4];
                if (d >= 4'd5) begin
                    acc[i*4 +: 4] = d + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits[s]};
        end
        return acc;
    endfunction

    assign padded   = PAD_W'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && q_ready);
    assign accept   = s_tvalid && s_tready;
    assign q_valid  = (state_reg == ST_DONE);
    assign q_data   = '{bcd: bcd_reg, trim: trim_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bcd_next   = bcd_reg;
        bits_next  = bits_reg;
        trim_next  = trim_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                bcd_next  = dd_step(bcd_reg, bits_reg[PAD_W-1 -: STEP_BITS]);
                bits_next = bits_reg << STEP_BITS;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(DD_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (q_ready) begin
                    state_next = accept ? ST_RUN : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (accept) begin
            cnt_next  = STEP_CNT_W'(1);
            bcd_next  = dd_step('0, padded[PAD_W-1 -: STEP_BITS]);
            bits_next = padded << STEP_BITS;
            trim_next = s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        bcd_reg  <= bcd_next;
        bits_reg <= bits_next;
        trim_reg <= trim_next;
    end

endmodule

[rtl/b2da_queue.sv]
// Two-entry queue between the converter front end and the character emitter
module b2da_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  b2da_pkg::q_entry_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output b2da_pkg::q_entry_t  out_data
);
    import b2da_pkg::*;

    q_entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                push, pop;

    assign in_ready  = (cnt_reg != QCNT_W'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[rtl/b2da_back.sv]
// Back end: walks the BCD digits most significant first and emits characters
module b2da_back #(
    parameter int DIGITS = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  b2da_pkg::q_entry_t            q_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [b2da_pkg::CHAR_W-1:0]   m_tdata,   // text_char
    output logic                          m_tlast    // last
);
    import b2da_pkg::*;

    localparam int NDIG     = (DIGITS > BCD_DIGITS) ? DIGITS : BCD_DIGITS;
    localparam int POS_W    = $clog2(NDIG);
    localparam int PADDED_W = 4 * NDIG;

    logic                active_reg, active_next;
    logic                term_reg, term_next;
    logic                started_reg, started_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    logic [PADDED_W-1:0] padded;
    logic [3:0]          digit;
    logic                adv, shown, hi_nz, pop;

    assign padded   = PADDED_W'(bcd_reg);
    assign digit    = padded[{pos_reg, 2'b00} +: 4];
    assign adv      = !out_valid_reg || m_tready;
    assign shown    = started_reg || (digit != 4'd0);
    assign pop      = q_valid && (!active_reg || (term_reg && adv));
    assign q_ready  = pop;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        hi_nz = 1'b0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (i >= DIGITS) begin
                hi_nz = hi_nz || (q_data.bcd[i*4 +: 4] != 4'd0);
            end
        end
    end

    always_comb begin
        active_next    = active_reg;
        term_next      = term_reg;
        started_next   = started_reg;
        pos_next       = pos_reg;
        bcd_next       = bcd_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (active_reg && !term_reg && (adv || !shown)) begin
            if (shown) begin
                out_valid_next = 1'b1;
                out_data_next  = CHAR_ZERO + {4'd0, digit};
                out_last_next  = 1'b0;
                started_next   = 1'b1;
            end
            if (pos_reg == '0) begin
                term_next = 1'b1;
            end else begin
                pos_next = pos_reg - 1'b1;
            end
        end
        if (active_reg && term_reg && adv) begin
            out_valid_next = 1'b1;
            out_data_next  = CHAR_NUL;
            out_last_next  = 1'b1;
            active_next    = 1'b0;
        end
        if (pop) begin
            active_next  = 1'b1;
            term_next    = 1'b0;
            started_next = !q_data.trim || hi_nz;
            pos_next     = POS_W'(DIGITS - 1);
            bcd_next     = q_data.bcd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            term_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
        started_reg  <= started_next;
        pos_reg      <= pos_next;
        bcd_reg      <= bcd_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

endmodule

[rtl/binary_to_decimal_ascii.sv]
// Top level of the binary to decimal ASCII converter
//
// Each request carries a 32-bit unsigned number and a trim flag and yields
// DIGITS decimal ASCII characters, most significant first, then a NUL
// character with m_tlast set; with trim set, leading zeros are dropped and a
// zero gives the NUL alone. The front end converts to BCD three bits a cycle
// and takes no new request before it hands the last one to the queue; the
// character emitter walks every digit position of each request, skipped digits
// included, and a two-entry queue between them lets either side stall.
module binary_to_decimal_ascii #(
    parameter int DIGITS = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [b2da_pkg::NUM_W-1:0]    s_tdata,   // [31:0] number
    input  logic                          s_tuser,   // [0] trim
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [b2da_pkg::CHAR_W-1:0]   m_tdata,   // [7:0] text_char
    output logic                          m_tlast    // last
);
    import b2da_pkg::*;

    `include "binary_to_decimal_ascii_macros.svh"

    logic     fq_valid, fq_ready, bq_valid, bq_ready;
    q_entry_t fq_data, bq_data;

    b2da_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    b2da_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    b2da_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (bq_valid),
        .q_ready  (bq_ready),
        .q_data   (bq_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `B2DA_ASSERT_NOW(a_term_is_nul, m_tvalid && m_tlast, m_tdata == CHAR_NUL, "terminator not NUL")
    `B2DA_ASSERT_NOW(a_digit_range, m_tvalid && !m_tlast, (m_tdata >= CHAR_ZERO) && (m_tdata <= CHAR_ZERO + 8'd9), "digit out of range")
    `B2DA_ASSERT_NEXT(a_front_busy, s_tvalid && s_tready, !s_tready, "front end took two requests in a row")

endmodule

[bench/binary_to_decimal_ascii_tb.sv]
// Self-checking bench for the binary to decimal ASCII converter: directed and random requests
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;
    import b2da_pkg::*;

    localparam int    DIGITS      = 10;
    localparam int    HALF_PERIOD = 6;
    localparam int    CYCLE_LIMIT = 250000;
    localparam int    RANDOM_N    = 130;
    localparam int    CALM_N      = 30;
    localparam int    DRAIN_AT    = 75;
    localparam int    PLAN_N      = 21;
    localparam string PREDICTED   = "*";

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              term;
    } text_char_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [NUM_W-1:0]  s_tdata  = '0;   // [31:0] number
    logic              s_tuser  = 1'b0; // [0] trim
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [CHAR_W-1:0] m_tdata;         // [7:0] text_char
    logic              m_tlast;

    text_char_t digits_due[$];
    int         mismatches = 0;
    int         cycles     = 0;
    int         stall_left = 0;
    bit         calm       = 1'b0;

    logic [NUM_W-1:0] plan_number [PLAN_N] = '{
        32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd9, 32'd10,
        32'd99, 32'd100, 32'd999999999, 32'd1000000000, 32'd1000000000,
        32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF,
        32'd123456789, 32'd12345, 32'd100000, 32'hFFFF_FFFE
    };
    bit plan_trim [PLAN_N] = '{
        0, 1, 0, 1, 1, 0, 1, 1,
        1, 0, 1, 1, 0,
        1, 0, 1, 0,
        1, 1, 1, 0
    };
    string plan_text [PLAN_N] = '{
        "0000000000", "", "4294967295", "4294967295", "1", "0000000001",
        PREDICTED, PREDICTED, PREDICTED, PREDICTED, "999999999", "1000000000",
        PREDICTED, PREDICTED, PREDICTED, PREDICTED, PREDICTED,
        "123456789", PREDICTED, PREDICTED, PREDICTED
    };

    binary_to_decimal_ascii #(
        .DIGITS(DIGITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    function automatic void spell_decimal(input logic [NUM_W-1:0] number, input bit trim);
        longint unsigned value;
        longint unsigned scale;
        value = number;
        scale = 1;
        for (int k = 1; k < DIGITS; k++)
            scale *= 10;
        for (int k = DIGITS - 1; k >= 0; k--) begin
            if (!(trim && value < scale))
                digits_due.push_back('{code: CHAR_ZERO + CHAR_W'((value / scale) % 10),
                                       term: 1'b0});
            scale /= 10;
        end
        digits_due.push_back('{code: CHAR_NUL, term: 1'b1});
    endfunction

    function automatic logic [NUM_W-1:0] pick_number();
        int unsigned span;
        span = 1;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                repeat ($urandom_range(1, 9)) span *= 10;
                return $urandom_range(0, span - 1);
            end
            2: begin
                repeat ($urandom_range(0, 9)) span *= 10;
                return span + $urandom_range(0, 2) - 1;
            end
            default: return $urandom_range(0, 1) ? ($urandom & $urandom) : ($urandom | $urandom);
        endcase
    endfunction

    task automatic offer_request(input logic [NUM_W-1:0] number, input bit trim);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= number;
        s_tuser  <= trim;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic hold_sender(input int gap);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
        s_tuser  <= $urandom_range(0, 1);
        repeat (gap - 1) @(negedge aclk);
    endtask

    task automatic maybe_hold_sender();
        if (!calm && $urandom_range(0, 2) == 0)
            hold_sender($urandom_range(1, 16));
    endtask

    // receiver stalls in bursts
    always @(negedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        text_char_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (digits_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected char %02h last %0b", m_tdata, m_tlast));
            end else begin
                due = digits_due.pop_front();
                if (m_tdata !== due.code)
                    flag_mismatch($sformatf("text_char %02h, want %02h", m_tdata, due.code));
                if (m_tlast !== due.term)
                    flag_mismatch($sformatf("last %0b, want %0b", m_tlast, due.term));
            end
        end
    end

    initial begin
        logic [NUM_W-1:0] number;
        bit               trim;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_N; i++) begin
            offer_request(plan_number[i], plan_trim[i]);
            if (plan_text[i] == PREDICTED) begin
                spell_decimal(plan_number[i], plan_trim[i]);
            end else begin
                for (int j = 0; j < plan_text[i].len(); j++)
                    digits_due.push_back('{code: plan_text[i][j], term: 1'b0});
                digits_due.push_back('{code: CHAR_NUL, term: 1'b1});
            end
            maybe_hold_sender();
        end

        for (int i = 0; i < RANDOM_N; i++) begin
            if (i == DRAIN_AT) begin
                hold_sender(1);
                while (digits_due.size() != 0) @(posedge aclk);
            end
            if (i == RANDOM_N - CALM_N)
                calm = 1'b1;
            number = pick_number();
            trim   = $urandom_range(0, 1);
            offer_request(number, trim);
            spell_decimal(number, trim);
            maybe_hold_sender();
        end
        hold_sender(1);

        while (digits_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/b2da_pkg.sv
rtl/b2da_front.sv
rtl/b2da_queue.sv
rtl/b2da_back.sv
rtl/binary_to_decimal_ascii.sv
bench/binary_to_decimal_ascii_tb.sv
